[src/glob_pattern_list_matcher_core_macros.svh]
// ---------------------------------------------------------------------------
// glob pattern list matcher assertion macros
// concurrent assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef GLOB_PATTERN_LIST_MATCHER_CORE_MACROS_SVH
`define GLOB_PATTERN_LIST_MATCHER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GPLM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GPLM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gplm_pkg.sv]
// ---------------------------------------------------------------------------
// gplm_pkg
// shared types, character codes and helpers of the glob pattern list matcher
// ---------------------------------------------------------------------------
package gplm_pkg;

    // default store depths
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int NAME_DEPTH_DEF    = 128;

    // special characters
    localparam logic [7:0] CH_ANY  = 8'h3F;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SEP  = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_PAT   = 2'd1,
        MODE_NAME  = 2'd2,
        MODE_END   = 2'd3
    } mode_t;

    // top level sequencing
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_WALK,
        TOP_DONE
    } top_state_t;

    // match walk sequencing
    typedef enum logic [2:0] {
        W_IDLE,
        W_SCAN_RD,
        W_SCAN_CHK,
        W_MATCH_RD,
        W_MATCH_CHK,
        W_TAIL_RD,
        W_TAIL_CHK
    } walk_state_t;

    // walk status back to the top level
    typedef struct packed {
        logic done;
        logic hit;
    } walk_stat_t;

    // fold upper case letters to lower case
    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

[src/gplm_ram.sv]
// ---------------------------------------------------------------------------
// gplm_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module gplm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/gplm_walker.sv]
// ---------------------------------------------------------------------------
// gplm_walker
// walks the pattern list segment by segment and matches each trimmed
// pattern against the stored name, one memory read step at a time
// ---------------------------------------------------------------------------
module gplm_walker #(
    parameter  int PD  = gplm_pkg::PATTERN_DEPTH_DEF,
    parameter  int ND  = gplm_pkg::NAME_DEPTH_DEF,
    localparam int PAW = $clog2(PD),
    localparam int PLW = $clog2(PD + 1),
    localparam int NAW = $clog2(ND),
    localparam int NLW = $clog2(ND + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [PLW-1:0]       pat_len,
    input  logic [NLW-1:0]       name_len,
    output logic [PAW-1:0]       pat_addr,
    input  logic [7:0]           pat_data,
    output logic [NAW-1:0]       name_addr,
    input  logic [7:0]           name_data,
    output gplm_pkg::walk_stat_t stat
);

    import gplm_pkg::*;

    walk_state_t    state_reg, state_next;
    logic [PLW-1:0] i_reg, i_next;
    logic [PLW-1:0] a_reg, a_next;
    logic [PLW-1:0] b_reg, b_next;
    logic           seen_reg, seen_next;
    logic [PLW-1:0] lo_reg, lo_next;
    logic [PLW-1:0] len_reg, len_next;
    logic [PLW-1:0] p_reg, p_next;
    logic [PLW-1:0] sp_reg, sp_next;
    logic [NLW-1:0] n_reg, n_next;
    logic [NLW-1:0] sn_reg, sn_next;
    logic           star_reg, star_next;
    logic           done_reg, done_next;
    logic           hit_reg, hit_next;

    logic           seg_end;
    logic           fail;
    logic           p_valid;
    logic [PLW-1:0] pat_sum;

    // read addresses
    assign pat_sum   = lo_reg + p_reg;
    assign pat_addr  = (state_reg == W_SCAN_RD) ? i_reg[PAW-1:0] : pat_sum[PAW-1:0];
    assign name_addr = n_reg[NAW-1:0];
    assign p_valid   = (p_reg < len_reg);

    // next state and walk bookkeeping
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        seen_next  = seen_reg;
        lo_next    = lo_reg;
        len_next   = len_reg;
        p_next     = p_reg;
        sp_next    = sp_reg;
        n_next     = n_reg;
        sn_next    = sn_reg;
        star_next  = star_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        seg_end    = 1'b0;
        fail       = 1'b0;

        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    if (pat_len == '0) begin
                        // empty list matches every name
                        done_next = 1'b1;
                        hit_next  = 1'b1;
                    end else begin
                        i_next     = '0;
                        seen_next  = 1'b0;
                        state_next = W_SCAN_RD;
                    end
                end
            end
            W_SCAN_RD: begin
                if (i_reg == pat_len) begin
                    seg_end = 1'b1;
                end else begin
                    state_next = W_SCAN_CHK;
                end
            end
            W_SCAN_CHK: begin
                if (pat_data == CH_SEP) begin
                    seg_end = 1'b1;
                end else begin
                    // track first and last non-blank byte of the segment
                    if (pat_data != CH_SP) begin
                        if (!seen_reg) begin
                            a_next = i_reg;
                        end
                        seen_next = 1'b1;
                        b_next    = i_reg + 1'b1;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = W_SCAN_RD;
                end
            end
            W_MATCH_RD: begin
                if (n_reg >= name_len) begin
                    state_next = W_TAIL_RD;
                end else begin
                    state_next = W_MATCH_CHK;
                end
            end
            W_MATCH_CHK: begin
                state_next = W_MATCH_RD;
                if (p_valid && (pat_data == CH_ANY || fold(pat_data) == fold(name_data))) begin
                    n_next = n_reg + 1'b1;
                    p_next = p_reg + 1'b1;
                end else if (p_valid && pat_data == CH_STAR) begin
                    star_next = 1'b1;
                    sp_next   = p_reg;
                    sn_next   = n_reg;
                    p_next    = p_reg + 1'b1;
                end else if (star_reg) begin
                    // back off to the last star, one name byte further on
                    p_next  = sp_reg + 1'b1;
                    sn_next = sn_reg + 1'b1;
                    n_next  = sn_reg + 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            W_TAIL_RD: begin
                if (p_valid) begin
                    state_next = W_TAIL_CHK;
                end else begin
                    done_next  = 1'b1;
                    hit_next   = 1'b1;
                    state_next = W_IDLE;
                end
            end
            W_TAIL_CHK: begin
                if (pat_data == CH_STAR) begin
                    p_next     = p_reg + 1'b1;
                    state_next = W_TAIL_RD;
                end else begin
                    fail = 1'b1;
                end
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase

        // end of a segment: match it if it holds anything
        if (seg_end) begin
            if (seen_reg) begin
                lo_next    = a_reg;
                len_next   = b_reg - a_reg;
                p_next     = '0;
                n_next     = '0;
                star_next  = 1'b0;
                state_next = W_MATCH_RD;
            end else if (i_reg == pat_len) begin
                done_next  = 1'b1;
                hit_next   = 1'b0;
                state_next = W_IDLE;
            end else begin
                i_next     = i_reg + 1'b1;
                state_next = W_SCAN_RD;
            end
        end

        // pattern failed: move on past its separator
        if (fail) begin
            if (i_reg == pat_len) begin
                done_next  = 1'b1;
                hit_next   = 1'b0;
                state_next = W_IDLE;
            end else begin
                i_next     = i_reg + 1'b1;
                seen_next  = 1'b0;
                state_next = W_SCAN_RD;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // walk position registers
    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        seen_reg <= seen_next;
        lo_reg   <= lo_next;
        len_reg  <= len_next;
        p_reg    <= p_next;
        sp_reg   <= sp_next;
        n_reg    <= n_next;
        sn_reg   <= sn_next;
        star_reg <= star_next;
        hit_reg  <= hit_next;
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_reg;

endmodule

[src/glob_pattern_list_matcher_core.sv]
// ---------------------------------------------------------------------------
// glob_pattern_list_matcher_core
// glob pattern list matcher with pattern and name byte stores in ram
// ---------------------------------------------------------------------------
// s_ channel: tuser carries the request kind (clear list, pattern byte, name
//   byte, end of name), tdata the byte; patterns are separated by ';', with
//   '?' and '*' as wildcards
// m_ channel: one result per end-of-name request, tdata bit 0 matched, bit 1
//   overflow (a store overflowed, matched then 0)
// requests: clear, pattern and name requests are taken back to back
// end of name: the walk scans each segment of the list for its trimmed
//   pattern, matches it against the name step by step and checks its
//   trailing stars, moving on to the next segment on a miss. With a store
//   overflowed the walk is skipped. s_tready stays low until the result is
//   posted, longer while an earlier result waits
// reset: aresetn clears both store lengths, the overflow flags and the result
//   valid flag; the ram contents are left as they are
// stall: a posted result waits in the output register while further requests
//   are taken; the next result waits for it
// ---------------------------------------------------------------------------
module glob_pattern_list_matcher_core #(
    parameter  int PATTERN_DEPTH = gplm_pkg::PATTERN_DEPTH_DEF,
    parameter  int NAME_DEPTH    = gplm_pkg::NAME_DEPTH_DEF,
    localparam int PAW           = $clog2(PATTERN_DEPTH),
    localparam int PLW           = $clog2(PATTERN_DEPTH + 1),
    localparam int NAW           = $clog2(NAME_DEPTH),
    localparam int NLW           = $clog2(NAME_DEPTH + 1)
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    import gplm_pkg::*;

    top_state_t     state_reg, state_next;
    logic [PLW-1:0] pat_len_reg, pat_len_next;
    logic           pat_ovf_reg, pat_ovf_next;
    logic [NLW-1:0] name_len_reg, name_len_next;
    logic           name_ovf_reg, name_ovf_next;
    logic           pend_hit_reg, pend_hit_next;
    logic           pend_ovf_reg, pend_ovf_next;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_data_reg, m_data_next;

    logic           s_acc;
    mode_t          mode;
    logic           pat_we;
    logic           name_we;
    logic           walk_start;
    logic [PAW-1:0] pat_rd_addr;
    logic [7:0]     pat_rd_data;
    logic [NAW-1:0] name_rd_addr;
    logic [7:0]     name_rd_data;
    walk_stat_t     walk_stat;

    assign s_acc   = s_tvalid && s_tready;
    assign mode    = mode_t'(s_tuser);
    assign pat_we  = s_acc && (mode == MODE_PAT) && (pat_len_reg < PLW'(PATTERN_DEPTH));
    assign name_we = s_acc && (mode == MODE_NAME) && (name_len_reg < NLW'(NAME_DEPTH));

    // request handling, result sequencing
    always_comb begin
        state_next    = state_reg;
        pat_len_next  = pat_len_reg;
        pat_ovf_next  = pat_ovf_reg;
        name_len_next = name_len_reg;
        name_ovf_next = name_ovf_reg;
        pend_hit_next = pend_hit_reg;
        pend_ovf_next = pend_ovf_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        walk_start    = 1'b0;
        s_tready      = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            TOP_IDLE: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    case (mode)
                        MODE_CLEAR: begin
                            pat_len_next = '0;
                            pat_ovf_next = 1'b0;
                        end
                        MODE_PAT: begin
                            if (pat_we) begin
                                pat_len_next = pat_len_reg + 1'b1;
                            end else begin
                                pat_ovf_next = 1'b1;
                            end
                        end
                        MODE_NAME: begin
                            if (name_we) begin
                                name_len_next = name_len_reg + 1'b1;
                            end else begin
                                name_ovf_next = 1'b1;
                            end
                        end
                        MODE_END: begin
                            if (pat_ovf_reg || name_ovf_reg) begin
                                pend_hit_next = 1'b0;
                                pend_ovf_next = 1'b1;
                                state_next    = TOP_DONE;
                            end else begin
                                pend_ovf_next = 1'b0;
                                walk_start    = 1'b1;
                                state_next    = TOP_WALK;
                            end
                        end
                        default: begin
                            state_next = TOP_IDLE;
                        end
                    endcase
                end
            end
            TOP_WALK: begin
                if (walk_stat.done) begin
                    pend_hit_next = walk_stat.hit;
                    state_next    = TOP_DONE;
                end
            end
            TOP_DONE: begin
                // post the result once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {6'd0, pend_ovf_reg, pend_hit_reg};
                    name_len_next = '0;
                    name_ovf_next = 1'b0;
                    state_next    = TOP_IDLE;
                end
            end
            default: begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TOP_IDLE;
            pat_len_reg  <= '0;
            pat_ovf_reg  <= 1'b0;
            name_len_reg <= '0;
            name_ovf_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pat_len_reg  <= pat_len_next;
            pat_ovf_reg  <= pat_ovf_next;
            name_len_reg <= name_len_next;
            name_ovf_reg <= name_ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        pend_hit_reg <= pend_hit_next;
        pend_ovf_reg <= pend_ovf_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // pattern byte store
    gplm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_DEPTH)
    ) u_pat_ram (
        .aclk    (aclk),
        .wr_en   (pat_we),
        .wr_addr (pat_len_reg[PAW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    // name byte store
    gplm_ram #(
        .WIDTH (8),
        .DEPTH (NAME_DEPTH)
    ) u_name_ram (
        .aclk    (aclk),
        .wr_en   (name_we),
        .wr_addr (name_len_reg[NAW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (name_rd_addr),
        .rd_data (name_rd_data)
    );

    // match walk
    gplm_walker #(
        .PD (PATTERN_DEPTH),
        .ND (NAME_DEPTH)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (walk_start),
        .pat_len   (pat_len_reg),
        .name_len  (name_len_reg),
        .pat_addr  (pat_rd_addr),
        .pat_data  (pat_rd_data),
        .name_addr (name_rd_addr),
        .name_data (name_rd_data),
        .stat      (walk_stat)
    );

endmodule

[src/gplm_checker.sv]
// ---------------------------------------------------------------------------
// gplm_checker
// port-level checks on the glob pattern list matcher, bound to the top level
// ---------------------------------------------------------------------------
`include "glob_pattern_list_matcher_core_macros.svh"

module gplm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    import gplm_pkg::*;

    logic end_req;

    assign end_req = s_tvalid && s_tready && (s_tuser == MODE_END);

    // a stalled result holds
    `GPLM_ASSERT_NXT(a_res_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    // overflow never reports a match
    `GPLM_ASSERT_IMP(a_ovf_no_hit, aclk, aresetn, m_tvalid && m_tdata[1],
        !m_tdata[0], "match reported with overflow")

    // padding bits stay zero
    `GPLM_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid,
        m_tdata[7:2] == 6'd0, "result padding not zero")

    // end of name blocks further requests while it is worked on
    `GPLM_ASSERT_NXT(a_end_busy, aclk, aresetn, end_req,
        !s_tready, "request taken during match walk")

endmodule

bind glob_pattern_list_matcher_core gplm_checker u_gplm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
